// ===== rtl/core/ajps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and constants for the jitter playout scheduler.
// No dependencies; every rtl/core file imports it.
package ajps_pkg;

    localparam int SPP_W      = 9;
    localparam int DLY_W      = 10;
    localparam int THR_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE   = 3'd4;

    localparam logic [SPP_W-1:0] RST_SAMPLES = 9'd80;
    localparam logic [DLY_W-1:0] RST_MIN     = 10'd60;
    localparam logic [DLY_W-1:0] RST_MAX     = 10'd400;
    localparam logic [THR_W-1:0] RST_ENTER   = 12'd240;
    localparam logic [THR_W-1:0] RST_LEAVE   = 12'd120;

    localparam int QUEUE_DEPTH_DEF = 2;

    // serial divider: 36-bit dividend covers the stamp span times 10
    localparam int DIV_W     = 36;
    localparam int DIV_CNT_W = 6;

    localparam int          RESYNC_LIMIT = 800;
    localparam logic [5:0]  WAIT_LIMIT   = 6'd50;

    // Q0.16 blend weights
    localparam logic [15:0] W_MEAN_OLD = 16'd62259;
    localparam logic [11:0] W_MEAN_NEW = 12'd3277;
    localparam logic [15:0] W_B_LOW    = 16'd63897;
    localparam logic [11:0] W_A_LOW    = 12'd1639;
    localparam logic [15:0] W_B_MID    = 16'd65404;
    localparam logic [11:0] W_A_MID    = 12'd132;
    localparam logic [15:0] W_B_HIGH   = 16'd64716;
    localparam logic [11:0] W_A_HIGH   = 12'd820;
    // floor(x/20) as (x*52429)>>20, exact for x below 17408
    localparam logic [15:0] RECIP_20   = 16'd52429;

    typedef struct packed {
        logic [31:0] arrival_ms;
        logic [15:0] seq_num;
        logic [31:0] media_stamp;
    } in_item_t;

    typedef struct packed {
        logic [31:0]      play_at_ms;
        logic             resynced;
        logic             in_spike;
        logic [DLY_W-1:0] base_delay_ms;
        logic [15:0]      jitter_ms;
        logic [15:0]      avg_jitter_ms;
        logic [15:0]      max_jitter_ms;
        logic [31:0]      lost_count;
    } out_item_t;

    typedef struct packed {
        logic [SPP_W-1:0] samples_per_10ms;
        logic [DLY_W-1:0] min_delay_ms;
        logic [DLY_W-1:0] max_delay_ms;
        logic [THR_W-1:0] spike_enter_ms;
        logic [THR_W-1:0] spike_leave_ms;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic [DLY_W-1:0] value;
    } base_load_t;

endpackage

// ===== rtl/core/adaptive_jitter_playout_scheduler.sv =====
`timescale 1ns / 1ps
// Adaptive jitter playout scheduler, top level: config registers, input queue, back end.
// Path from input beat to result: the first packet goes from the queue to its result;
// later ones take the queue, three divisions on the shared serial divider, then math.
// The back end takes one packet at a time; result stalls hold its final state.
// Reset: async active low; registers return to defaults, base delay to min delay.
module adaptive_jitter_playout_scheduler
    import ajps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    base_load_t base_ld;
    logic       q_valid, q_ready;
    in_item_t   q_data;

    assign base_ld.load  = cfg_we && (cfg_idx == CFG_MIN);
    assign base_ld.value = cfg_data[DLY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_10ms <= RST_SAMPLES;
            cfg_reg.min_delay_ms     <= RST_MIN;
            cfg_reg.max_delay_ms     <= RST_MAX;
            cfg_reg.spike_enter_ms   <= RST_ENTER;
            cfg_reg.spike_leave_ms   <= RST_LEAVE;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_SAMPLES: cfg_reg.samples_per_10ms <= cfg_data[SPP_W-1:0];
                CFG_MIN:     cfg_reg.min_delay_ms     <= cfg_data[DLY_W-1:0];
                CFG_MAX:     cfg_reg.max_delay_ms     <= cfg_data[DLY_W-1:0];
                CFG_ENTER:   cfg_reg.spike_enter_ms   <= cfg_data[THR_W-1:0];
                CFG_LEAVE:   cfg_reg.spike_leave_ms   <= cfg_data[THR_W-1:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    ajps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    ajps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .base_ld   (base_ld),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/ajps_queue.sv =====
`timescale 1ns / 1ps
// Front end: input queue that takes packet beats and hands them to the back end.
// Uses ajps_pkg for the item type.
module ajps_queue
    import ajps_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output in_item_t out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    in_item_t       mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/ajps_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle, shared by the back end.
// Uses ajps_pkg for widths.
module ajps_div
    import ajps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [SPP_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     dq_reg;
    logic [SPP_W-1:0]     rem_reg, dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [SPP_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh   = {rem_reg, dq_reg[DIV_W-1]};
    assign fits     = (rem_sh >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = dq_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? SPP_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[SPP_W-1:0];
            dq_reg  <= {dq_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/ajps_back.sv =====
`timescale 1ns / 1ps
// Back end: per-packet sequencer for jitter, offset, spike mode and base delay.
// Uses ajps_pkg and ajps_div; drives the registered result port.
module ajps_back
    import ajps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  base_load_t base_ld,
    input  logic       q_valid,
    output logic       q_ready,
    input  in_item_t   q_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DIV1  = 12'b000000000010,
        S_DIV2  = 12'b000000000100,
        S_DIV3  = 12'b000000001000,
        S_JIT   = 12'b000000010000,
        S_STAT  = 12'b000000100000,
        S_OFF   = 12'b000001000000,
        S_ADJ   = 12'b000010000000,
        S_MUL   = 12'b000100000000,
        S_FIN   = 12'b001000000000,
        S_FIRST = 12'b010000000000,
        S_RSY   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // persistent state
    in_item_t          item_reg;
    logic              started_reg, spike_reg;
    logic [31:0]       first_arr_reg, first_st_reg, last_arr_reg, last_st_reg;
    logic [15:0]       high_seq_reg, peak_reg, mean_reg;
    logic [31:0]       lost_reg, pj_reg, poff_reg, savg_reg;
    logic [DLY_W-1:0]  base_reg;
    logic [5:0]        wait_reg;

    // per-packet work registers
    logic                neg_reg;
    logic signed [32:0]  q1_reg, q2_reg;
    logic [31:0]         dur_reg, jit_reg;
    logic signed [37:0]  inst_reg;
    logic [43:0]         mpa_reg;
    logic [31:0]         mpb_reg;
    logic signed [39:0]  off_reg;
    logic signed [41:0]  adj_reg;
    logic signed [54:0]  pa_reg;
    logic [25:0]         pb_reg;
    logic [DLY_W-1:0]    add_reg;

    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      emit_now;

    // divider hookup
    logic             div_start, div_done, div_neg;
    logic [DIV_W-1:0] div_dividend, div_quot;
    logic [SPP_W-1:0] spp;
    logic [31:0]      sd_in, sd_mag;
    logic signed [32:0] q_signed;

    // combinational datapath
    logic signed [37:0] q1x10, q2x10, d_val, inst_val;
    logic [37:0]        absd, jsum;
    logic [31:0]        jit_val;
    logic signed [16:0] jump;
    logic [32:0]        lost_sum;
    logic               resync;
    logic [31:0]        savg_val;
    logic [44:0]        msum;
    logic [15:0]        mean_val;
    logic signed [31:0] poff_s;
    logic signed [52:0] num, num_r;
    logic signed [33:0] spk_sum;
    logic signed [39:0] off_val;
    logic signed [41:0] adj_val, max_s;
    logic signed [43:0] adj4, base5;
    logic [15:0]        wb_sel;
    logic [11:0]        wa_sel;
    logic [DLY_W-1:0]   add_sel;
    logic signed [54:0] psum;
    logic signed [38:0] tmp;
    logic signed [11:0] nb, base_s;
    logic [5:0]         wait_val;
    logic [DLY_W-1:0]   base_fin;
    logic [14:0]        b17, m20;
    logic [29:0]        b17r;
    logic [DLY_W-1:0]   base_rsy;
    logic [33:0]        pj3;

    assign q_ready   = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_now  = out_free && (state_reg inside {S_FIN, S_FIRST, S_RSY});
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign spp       = (cfg.samples_per_10ms == '0) ? SPP_W'(1) : cfg.samples_per_10ms;

    ajps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (spp),
        .done     (div_done),
        .quotient (div_quot)
    );

    // operand selection for the three divisions
    always_comb
    begin
        div_start = 1'b0;
        sd_in     = '0;
        case (state_reg)
            S_IDLE:
            begin
                div_start = q_valid && started_reg;
                sd_in     = q_data.media_stamp - last_st_reg;
            end
            S_DIV1:
            begin
                div_start = div_done;
                sd_in     = item_reg.media_stamp - first_st_reg;
            end
            S_DIV2:
            begin
                div_start = div_done;
                sd_in     = item_reg.media_stamp - first_st_reg;
            end
            default:
            begin
                div_start = 1'b0;
                sd_in     = '0;
            end
        endcase
        div_neg = sd_in[31];
        sd_mag  = div_neg ? (32'd0 - sd_in) : sd_in;
        if (state_reg == S_DIV2)
        begin
            // duration: unsigned stamp span times 10
            div_dividend = (DIV_W'(sd_in) << 3) + (DIV_W'(sd_in) << 1);
        end
        else
        begin
            div_dividend = DIV_W'(sd_mag);
        end
        q_signed = neg_reg ? (33'sd0 - $signed({1'b0, div_quot[31:0]}))
                           : $signed({1'b0, div_quot[31:0]});
    end

    // jitter, offset and sequence tracking
    always_comb
    begin
        q1x10    = (38'(q1_reg) <<< 3) + (38'(q1_reg) <<< 1);
        q2x10    = (38'(q2_reg) <<< 3) + (38'(q2_reg) <<< 1);
        d_val    = 38'($signed(item_reg.arrival_ms - last_arr_reg)) - q1x10;
        inst_val = 38'($signed(item_reg.arrival_ms - first_arr_reg)) - q2x10;
        absd     = d_val[37] ? 38'(38'sd0 - d_val) : 38'(d_val);
        jsum     = ({6'b0, pj_reg} << 4) - {6'b0, pj_reg} + absd;
        jit_val  = (jsum[37:36] != 2'b0) ? 32'hFFFF_FFFF : jsum[35:4];
        resync   = (inst_val >= 38'sd800) || (inst_val <= -38'sd800);
        jump     = $signed({1'b0, item_reg.seq_num}) - $signed({1'b0, high_seq_reg});
        lost_sum = {1'b0, lost_reg} + 33'(jump[15:0]) - 33'd1;
    end

    // spike average, mean, offset and clamped adjust
    always_comb
    begin
        savg_val = {1'b0, savg_reg[31:1]} + {1'b0, jit_reg[31:1]};
        msum     = {1'b0, mpa_reg} + {13'b0, mpb_reg};
        mean_val = (msum[44:32] != '0) ? 16'hFFFF : msum[31:16];
        poff_s   = $signed(poff_reg);
        num      = (53'(inst_reg) <<< 14) + (53'(poff_s) <<< 15) + (53'(poff_s) <<< 14);
        num_r    = num + (num[52] ? 53'sd65535 : 53'sd0);
        spk_sum  = 34'(poff_s) + $signed({2'b0, jit_reg});
        if (!spike_reg)
        begin
            off_val = 40'(num_r >>> 16);
        end
        else if (spk_sum > 34'sd2147483647)
        begin
            off_val = 40'sd2147483647;
        end
        else
        begin
            off_val = 40'(spk_sum);
        end
        max_s   = $signed({32'b0, cfg.max_delay_ms});
        adj_val = 42'(off_reg) + $signed({9'b0, jit_reg, 1'b0});
        if (adj_val > max_s)
        begin
            adj_val = max_s;
        end
    end

    // blend branch, product sum and base update
    always_comb
    begin
        adj4  = 44'(adj_reg) <<< 2;
        base5 = $signed({32'b0, base_reg, 2'b0}) + $signed({34'b0, base_reg});
        if (adj_reg < 0 && inst_reg < 0)
        begin
            wb_sel  = W_B_LOW;
            wa_sel  = W_A_LOW;
            add_sel = base_reg;
        end
        else if (adj4 < base5)
        begin
            wb_sel  = W_B_MID;
            wa_sel  = W_A_MID;
            add_sel = base_reg;
        end
        else
        begin
            wb_sel  = W_B_HIGH;
            wa_sel  = W_A_HIGH;
            add_sel = adj_reg[DLY_W-1:0];
        end

        psum   = pa_reg + $signed({29'b0, pb_reg});
        psum   = psum + (psum[54] ? 55'sd65535 : 55'sd0);
        tmp    = 39'(psum >>> 16);
        base_s = $signed({2'b0, base_reg});
        if (tmp < 39'(base_s))
        begin
            if (wait_reg >= WAIT_LIMIT)
            begin
                nb       = base_s - 12'sd1;
                wait_val = '0;
            end
            else
            begin
                nb       = base_s;
                wait_val = wait_reg + 1'b1;
            end
        end
        else
        begin
            nb       = tmp[11:0];
            wait_val = '0;
        end
        if (nb < $signed({2'b0, cfg.min_delay_ms}))
        begin
            nb = $signed({2'b0, cfg.min_delay_ms});
        end
        if (nb > $signed({2'b0, cfg.max_delay_ms}))
        begin
            nb = $signed({2'b0, cfg.max_delay_ms});
        end
        base_fin = nb[DLY_W-1:0];

        // resync shrink of the base delay
        b17      = ({5'b0, base_reg} << 4) + {5'b0, base_reg};
        m20      = ({5'b0, cfg.min_delay_ms} << 4) + ({5'b0, cfg.min_delay_ms} << 2);
        b17r     = b17 * RECIP_20;
        base_rsy = (b17 > m20) ? b17r[29:20] : cfg.min_delay_ms;
        pj3      = {1'b0, pj_reg, 1'b0} + {2'b0, pj_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = started_reg ? S_DIV1 : S_FIRST;
                end
            end
            S_DIV1:  if (div_done) state_next = S_DIV2;
            S_DIV2:  if (div_done) state_next = S_DIV3;
            S_DIV3:  if (div_done) state_next = S_JIT;
            S_JIT:   state_next = resync ? S_RSY : S_STAT;
            S_STAT:  state_next = S_OFF;
            S_OFF:   state_next = S_ADJ;
            S_ADJ:   state_next = S_MUL;
            S_MUL:   state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            S_FIRST: if (out_free) state_next = S_IDLE;
            S_RSY:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // work registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= q_data;
                neg_reg  <= div_neg;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    q1_reg  <= q_signed;
                    neg_reg <= div_neg;
                end
            end
            S_DIV2:  if (div_done) q2_reg <= q_signed;
            S_DIV3:  if (div_done) dur_reg <= div_quot[31:0];
            S_JIT:
            begin
                jit_reg  <= jit_val;
                inst_reg <= inst_val;
            end
            S_STAT:
            begin
                mpa_reg <= jit_reg * W_MEAN_NEW;
                mpb_reg <= mean_reg * W_MEAN_OLD;
            end
            S_OFF:   off_reg <= off_val;
            S_ADJ:   adj_reg <= adj_val;
            S_MUL:
            begin
                pa_reg  <= $signed({1'b0, wa_sel}) * adj_reg;
                pb_reg  <= wb_sel * base_reg;
                add_reg <= add_sel;
            end
            default:
            begin
                item_reg <= item_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            spike_reg     <= 1'b0;
            first_arr_reg <= '0;
            first_st_reg  <= '0;
            last_arr_reg  <= '0;
            last_st_reg   <= '0;
            high_seq_reg  <= '0;
            lost_reg      <= '0;
            pj_reg        <= '0;
            poff_reg      <= '0;
            peak_reg      <= '0;
            mean_reg      <= '0;
            savg_reg      <= '0;
            base_reg      <= RST_MIN;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ready && !emit_now)
            begin
                out_valid_reg <= 1'b0;
            end
            if (base_ld.load)
            begin
                base_reg <= base_ld.value;
            end
            case (state_reg)
                S_JIT:
                begin
                    if (jump >= 17'sd1)
                    begin
                        high_seq_reg <= item_reg.seq_num;
                    end
                    if (jump > 17'sd1)
                    begin
                        lost_reg <= lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];
                    end
                    else if (jump < 17'sd0 && lost_reg != '0)
                    begin
                        lost_reg <= lost_reg - 1'b1;
                    end
                end
                S_STAT:
                begin
                    if (jit_reg > {16'b0, peak_reg})
                    begin
                        peak_reg <= (jit_reg[31:16] != '0) ? 16'hFFFF : jit_reg[15:0];
                    end
                    if (!spike_reg)
                    begin
                        if (jit_reg > {20'b0, cfg.spike_enter_ms})
                        begin
                            savg_reg  <= '0;
                            spike_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        savg_reg <= savg_val;
                        if (savg_val < {20'b0, cfg.spike_leave_ms})
                        begin
                            spike_reg <= 1'b0;
                        end
                    end
                end
                S_OFF:   mean_reg <= mean_val;
                S_FIN:
                begin
                    if (out_free)
                    begin
                        base_reg      <= base_fin;
                        wait_reg      <= wait_val;
                        last_arr_reg  <= item_reg.arrival_ms;
                        last_st_reg   <= item_reg.media_stamp;
                        poff_reg      <= off_reg[31:0];
                        pj_reg        <= jit_reg;
                        out_valid_reg <= 1'b1;
                        out_reg.play_at_ms    <= dur_reg + first_arr_reg + 32'(add_reg);
                        out_reg.resynced      <= 1'b0;
                        out_reg.in_spike      <= spike_reg;
                        out_reg.base_delay_ms <= base_fin;
                        out_reg.jitter_ms     <= (jit_reg[31:16] != '0) ? 16'hFFFF
                                                                        : jit_reg[15:0];
                        out_reg.avg_jitter_ms <= mean_reg;
                        out_reg.max_jitter_ms <= peak_reg;
                        out_reg.lost_count    <= lost_reg;
                    end
                end
                S_FIRST, S_RSY:
                begin
                    if (out_free)
                    begin
                        started_reg   <= 1'b1;
                        first_arr_reg <= item_reg.arrival_ms;
                        last_arr_reg  <= item_reg.arrival_ms;
                        first_st_reg  <= item_reg.media_stamp;
                        last_st_reg   <= item_reg.media_stamp;
                        high_seq_reg  <= item_reg.seq_num;
                        lost_reg      <= '0;
                        peak_reg      <= '0;
                        mean_reg      <= '0;
                        poff_reg      <= '0;
                        out_valid_reg <= 1'b1;
                        out_reg.resynced      <= 1'b1;
                        out_reg.jitter_ms     <= '0;
                        out_reg.avg_jitter_ms <= '0;
                        out_reg.max_jitter_ms <= '0;
                        out_reg.lost_count    <= '0;
                        if (state_reg == S_RSY)
                        begin
                            // offset resync: leave spike mode, shrink the base
                            spike_reg <= 1'b0;
                            savg_reg  <= '0;
                            wait_reg  <= '0;
                            base_reg  <= base_rsy;
                            pj_reg    <= {1'b0, pj3[33:3]};
                            out_reg.play_at_ms    <= item_reg.arrival_ms + 32'(base_rsy);
                            out_reg.in_spike      <= 1'b0;
                            out_reg.base_delay_ms <= base_rsy;
                        end
                        else
                        begin
                            pj_reg <= '0;
                            out_reg.play_at_ms    <= item_reg.arrival_ms + 32'(base_reg);
                            out_reg.in_spike      <= spike_reg;
                            out_reg.base_delay_ms <= base_reg;
                        end
                    end
                end
                default:
                begin
                    started_reg <= started_reg;
                end
            endcase
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for adaptive_jitter_playout_scheduler: packet streams, config sweeps.
// Depends on rtl/core/ajps_pkg.sv and the scheduler RTL; holds its own playout predictor.

class playout_scoreboard;
    ajps_pkg::out_item_t exp_q[$];
    int        errors;
    int        n_results;
    int        n_resync;
    int        n_spike;
    bit [8:0]  r_spp;
    bit [9:0]  r_min;
    bit [9:0]  r_max;
    bit [11:0] r_enter;
    bit [11:0] r_leave;
    bit        started;
    bit        spike;
    bit [31:0] first_arr;
    bit [31:0] first_st;
    bit [31:0] last_arr;
    bit [31:0] last_st;
    bit [31:0] lost;
    bit [31:0] recv;
    bit [31:0] prev_jit;
    bit [31:0] prev_off;
    bit [31:0] spike_avg;
    bit [15:0] hseq;
    bit [15:0] peak;
    bit [15:0] mean;
    bit [9:0]  base;
    int        dwait;

    function new();
        r_spp   = ajps_pkg::RST_SAMPLES;
        r_min   = ajps_pkg::RST_MIN;
        r_max   = ajps_pkg::RST_MAX;
        r_enter = ajps_pkg::RST_ENTER;
        r_leave = ajps_pkg::RST_LEAVE;
        base    = ajps_pkg::RST_MIN;
    endfunction

    function void set_reg(logic [2:0] idx, logic [11:0] val);
        case (idx)
            ajps_pkg::CFG_SAMPLES: r_spp = val[8:0];
            ajps_pkg::CFG_MIN:
            begin
                r_min = val[9:0];
                base  = val[9:0];
            end
            ajps_pkg::CFG_MAX:     r_max = val[9:0];
            ajps_pkg::CFG_ENTER:   r_enter = val;
            ajps_pkg::CFG_LEAVE:   r_leave = val;
            default: ;
        endcase
    endfunction

    static function longint s32(bit [31:0] v);
        return longint'(int'(v));
    endfunction

    static function longint sat32(longint v);
        return (v > 64'sd4294967295) ? 64'sd4294967295 : v;
    endfunction

    static function bit [15:0] sat16(longint v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function void latch(ajps_pkg::in_item_t p);
        started   = 1;
        first_arr = p.arrival_ms;
        last_arr  = p.arrival_ms;
        first_st  = p.media_stamp;
        last_st   = p.media_stamp;
        hseq      = p.seq_num;
        recv      = 1;
        lost      = 0;
        peak      = 0;
        mean      = 0;
    endfunction

    // compute the schedule for one accepted packet and queue it
    function void note_packet(ajps_pkg::in_item_t p);
        ajps_pkg::out_item_t e;
        longint    spp, d, absd, jump, jitl, inst, poff, off, adjust, dur, b, tmp, add, nb;
        bit [31:0] arr, st, sd;
        arr = p.arrival_ms;
        st  = p.media_stamp;
        spp = (r_spp == 0) ? 1 : longint'(r_spp);
        e   = '0;
        jitl = 0;
        if (!started)
        begin
            latch(p);
            prev_off = 0;
            prev_jit = 0;
            e.play_at_ms = arr + base;
            e.resynced   = 1;
        end
        else
        begin
            recv = sat32(longint'(recv) + 1);
            d = s32(arr - last_arr) - (s32(st - last_st) / spp) * 10;
            absd = (d < 0) ? -d : d;
            jump = longint'(p.seq_num) - longint'(hseq);
            if (jump >= 1) hseq = p.seq_num;
            if (jump > 1) lost = sat32(longint'(lost) + jump - 1);
            if (jump < 0 && lost != 0) lost = lost - 1;
            jitl = sat32((15 * longint'(prev_jit) + absd) / 16);
            inst = s32(arr - first_arr) - (s32(st - first_st) / spp) * 10;
            if (inst >= 800 || inst <= -800)
            begin
                spike     = 0;
                spike_avg = 0;
                dwait     = 0;
                b = longint'(base);
                if (17 * b > 20 * longint'(r_min)) b = (17 * b) / 20;
                else b = longint'(r_min);
                base = b[9:0];
                tmp = ((longint'(prev_jit) * 3) / 4) / 2;
                prev_jit = tmp[31:0];
                prev_off = 0;
                latch(p);
                e.play_at_ms = arr + base;
                e.resynced   = 1;
                jitl = 0;
            end
            else
            begin
                if (jitl > longint'(peak)) peak = sat16(jitl);
                mean = sat16((longint'(mean) * 62259 + jitl * 3277) / 65536);
                if (!spike)
                begin
                    if (jitl > longint'(r_enter))
                    begin
                        spike_avg = 0;
                        spike     = 1;
                    end
                end
                else
                begin
                    tmp = longint'(spike_avg) / 2 + jitl / 2;
                    spike_avg = tmp[31:0];
                    if (spike_avg < r_leave) spike = 0;
                end
                poff = s32(prev_off);
                if (!spike) off = (16384 * inst + 49152 * poff) / 65536;
                else
                begin
                    off = poff + jitl;
                    if (off > 64'sd2147483647) off = 64'sd2147483647;
                end
                adjust = off + 2 * jitl;
                if (adjust > longint'(r_max)) adjust = longint'(r_max);
                sd  = st - first_st;
                dur = (longint'(sd) * 10) / spp;
                b   = longint'(base);
                if (adjust < 0 && inst < 0)
                begin
                    add = b;
                    tmp = (63897 * b + 1639 * adjust) / 65536;
                end
                else if (4 * adjust < 5 * b)
                begin
                    add = b;
                    tmp = (65404 * b + 132 * adjust) / 65536;
                end
                else
                begin
                    add = adjust;
                    tmp = (64716 * b + 820 * adjust) / 65536;
                end
                nb = dur + longint'(first_arr) + add;
                e.play_at_ms = nb[31:0];
                nb = b;
                if (tmp < b)
                begin
                    // hold off decreases until the wait count has run out
                    if (dwait >= 50)
                    begin
                        nb    = b - 1;
                        dwait = 0;
                    end
                    else dwait++;
                end
                else
                begin
                    dwait = 0;
                    nb    = tmp;
                end
                if (nb < longint'(r_min)) nb = longint'(r_min);
                if (nb > longint'(r_max)) nb = longint'(r_max);
                base     = nb[9:0];
                last_arr = arr;
                last_st  = st;
                prev_off = off[31:0];
                prev_jit = jitl[31:0];
            end
        end
        e.in_spike      = spike;
        e.base_delay_ms = base;
        e.jitter_ms     = sat16(jitl);
        e.avg_jitter_ms = mean;
        e.max_jitter_ms = peak;
        e.lost_count    = lost;
        exp_q.push_back(e);
    endfunction

    function void check_result(ajps_pkg::out_item_t got);
        ajps_pkg::out_item_t e;
        n_results++;
        if (got.resynced) n_resync++;
        if (got.in_spike) n_spike++;
        if (exp_q.size() == 0)
        begin
            $error("unexpected result beat: %p", got);
            errors++;
            return;
        end
        e = exp_q.pop_front();
        if (got.play_at_ms !== e.play_at_ms)
        begin
            $error("play_at_ms exp %0d got %0d", e.play_at_ms, got.play_at_ms);
            errors++;
        end
        if (got.resynced !== e.resynced)
        begin
            $error("resynced exp %0d got %0d", e.resynced, got.resynced);
            errors++;
        end
        if (got.in_spike !== e.in_spike)
        begin
            $error("in_spike exp %0d got %0d", e.in_spike, got.in_spike);
            errors++;
        end
        if (got.base_delay_ms !== e.base_delay_ms)
        begin
            $error("base_delay_ms exp %0d got %0d", e.base_delay_ms, got.base_delay_ms);
            errors++;
        end
        if (got.jitter_ms !== e.jitter_ms)
        begin
            $error("jitter_ms exp %0d got %0d", e.jitter_ms, got.jitter_ms);
            errors++;
        end
        if (got.avg_jitter_ms !== e.avg_jitter_ms)
        begin
            $error("avg_jitter_ms exp %0d got %0d", e.avg_jitter_ms, got.avg_jitter_ms);
            errors++;
        end
        if (got.max_jitter_ms !== e.max_jitter_ms)
        begin
            $error("max_jitter_ms exp %0d got %0d", e.max_jitter_ms, got.max_jitter_ms);
            errors++;
        end
        if (got.lost_count !== e.lost_count)
        begin
            $error("lost_count exp %0d got %0d", e.lost_count, got.lost_count);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import ajps_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 600;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 0;
    out_item_t             out_data;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_SAMPLES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    playout_scoreboard sb = new();
    bit        quiet;
    bit        hold_req;
    int        n_pkts;
    int        idle_cycles;
    bit [31:0] nom_arr;
    bit [31:0] nom_st;
    bit [15:0] nom_seq;
    int        cur_spp;

    adaptive_jitter_playout_scheduler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && out_ready) sb.check_result(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready = 0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            else out_ready = 1;
        end
    end

    task automatic send_packet(in_item_t p);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid = 1;
        in_data  = p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_packet(p);
        n_pkts++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 0;
        while (sb.exp_q.size() != 0) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we   = 1;
        cfg_idx  = idx;
        cfg_data = val[CFG_DATA_W-1:0];
        sb.set_reg(idx, cfg_data);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic set_config(int spp, int mn, int mx, int en, int lv);
        drain();
        repeat (150) @(negedge clk);
        cfg_write(CFG_SAMPLES, spp);
        cfg_write(CFG_MIN, mn);
        cfg_write(CFG_MAX, mx);
        cfg_write(CFG_ENTER, en);
        cfg_write(CFG_LEAVE, lv);
        cur_spp = (spp == 0) ? 1 : spp;
    endtask

    function automatic in_item_t pkt(bit [31:0] a, bit [15:0] s, bit [31:0] m);
        in_item_t p;
        p.arrival_ms  = a;
        p.seq_num     = s;
        p.media_stamp = m;
        return p;
    endfunction

    // mostly a steady 20 ms stream with random delay, loss, reorder, spikes and resyncs
    task automatic run_stream(int n, int jit_hi, int spike_pct, int resync_pct, int noise_pct);
        int        r;
        bit [31:0] a;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < noise_pct)
            begin
                send_packet(pkt($urandom, $urandom_range(0, 65535), $urandom));
                continue;
            end
            nom_arr = nom_arr + 20;
            nom_st  = nom_st + 2 * cur_spp;
            r = $urandom_range(0, 99);
            if (r < 8) nom_seq = nom_seq + $urandom_range(2, 6);
            else if (r < 14) nom_seq = nom_seq - 1;
            else nom_seq = nom_seq + 1;
            a = nom_arr + $urandom_range(0, jit_hi);
            r = $urandom_range(0, 99);
            if (r < resync_pct)
            begin
                if ($urandom_range(0, 1)) a = nom_arr + $urandom_range(850, 3000);
                else a = nom_arr - $urandom_range(850, 3000);
            end
            else if (r < resync_pct + spike_pct) a = nom_arr + $urandom_range(250, 700);
            send_packet(pkt(a, nom_seq, nom_st));
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        cur_spp = RST_SAMPLES;

        // directed: wrap extremes, loss, reorder, spike and both resync directions
        send_packet(pkt(32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FF00));
        send_packet(pkt(32'h0000_0004, 16'h0000, 32'h0000_00A0));
        send_packet(pkt(32'h0000_0018, 16'h0005, 32'h0000_01E0));
        send_packet(pkt(32'h0000_002C, 16'h0003, 32'h0000_0320));
        send_packet(pkt(32'h0000_0300, 16'h0006, 32'h0000_0460));
        send_packet(pkt(32'h0000_0314, 16'h0007, 32'h0000_05A0));
        send_packet(pkt(32'h0000_1000, 16'h0008, 32'h0000_06E0));
        send_packet(pkt(32'h0000_1014, 16'h0009, 32'h0000_0820));
        send_packet(pkt(32'h0000_0100, 16'h000A, 32'h0000_0960));
        send_packet(pkt(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_packet(pkt(32'h0000_0000, 16'h0000, 32'h0000_0000));
        send_packet(pkt(32'h7FFF_FFFF, 16'h8000, 32'h8000_0000));
        send_packet(pkt(32'h8000_0000, 16'h7FFF, 32'h7FFF_FFFF));
        nom_arr = 32'hFFFF_F000;
        nom_st  = 32'hFFFF_0000;
        nom_seq = 16'hFFF0;
        send_packet(pkt(nom_arr, nom_seq, nom_st));
        run_stream(50, 15, 6, 2, 5);

        set_config(0, 0, 1023, 0, 0);
        run_stream(60, 40, 5, 2, 5);

        set_config(480, 1023, 1023, 4095, 4095);
        run_stream(55, 30, 10, 3, 5);

        // min above max: base pinned at max, but resync results set it to min
        set_config(511, 200, 100, 50, 4095);
        run_stream(55, 60, 10, 3, 5);

        set_config(160, 20, 300, 60, 30);
        run_stream(20, 30, 10, 2, 5);
        hold_req = 1;
        run_stream(25, 30, 10, 2, 5);
        drain();
        run_stream(25, 30, 10, 2, 5);

        // big jitter lifts the base, then a calm run lets it creep back down
        set_config(1, 0, 1023, 4095, 0);
        run_stream(25, 150, 0, 0, 0);
        run_stream(90, 0, 0, 0, 0);

        set_config($urandom_range(1, 480), $urandom_range(0, 200), $urandom_range(300, 1023),
                   $urandom_range(50, 400), $urandom_range(20, 200));
        quiet = 1;
        run_stream(60, 25, 8, 2, 5);

        drain();
        repeat (200) @(negedge clk);
        $display("%0d packets sent over 7 config settings; %0d results, %0d resyncs, %0d in spike",
                 n_pkts, sb.n_results, sb.n_resync, sb.n_spike);
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== adaptive_jitter_playout_scheduler.f =====
rtl/core/ajps_pkg.sv
rtl/core/ajps_queue.sv
rtl/core/ajps_div.sv
rtl/core/ajps_back.sv
rtl/core/adaptive_jitter_playout_scheduler.sv
dv/tb_top.sv
